### design/qos_pkg.sv
package qos_pkg;

    localparam int ACC_BITS = 64;

    typedef enum logic [2:0]
    {
        REQ_NONE      = 3'd0,
        REQ_ARRIVAL   = 3'd1,
        REQ_DEPARTURE = 3'd2,
        REQ_END       = 3'd3,
        REQ_PROBE     = 3'd4,
        REQ_CLEAR     = 3'd5
    } req_t;

    typedef enum logic [1:0]
    {
        STATUS_OK           = 2'd0,
        STATUS_BACKWARDS    = 2'd1,
        STATUS_EMPTY_DEPART = 2'd2
    } status_t;

    function automatic logic [ACC_BITS-1:0] sat_add(
        input logic [ACC_BITS-1:0] a,
        input logic [ACC_BITS-1:0] b
    );
        logic [ACC_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
    endfunction

endpackage

### design/qos_area_acc.sv
module qos_area_acc #(
    parameter int TIME_BITS   = 32,
    parameter int CLIENT_BITS = 16
) (
    input  logic [qos_pkg::ACC_BITS-1:0] acc_in,
    input  logic [CLIENT_BITS-1:0]       weight,
    input  logic [TIME_BITS-1:0]         span,
    output logic [qos_pkg::ACC_BITS-1:0] acc_out
);
    import qos_pkg::*;

    localparam int PROD_BITS = CLIENT_BITS + TIME_BITS;
    localparam int EXT_BITS  = (PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS + 1;

    logic [PROD_BITS-1:0]  product;
    logic [EXT_BITS-1:0]   product_ext;
    logic [ACC_BITS-1:0]   product_sat;

    always_comb
    begin
        product     = PROD_BITS'(weight) * PROD_BITS'(span);
        product_ext = EXT_BITS'(product);
        product_sat = (|product_ext[EXT_BITS-1:ACC_BITS]) ? {ACC_BITS{1'b1}}
                                                           : product_ext[ACC_BITS-1:0];
        acc_out     = sat_add(acc_in, product_sat);
    end

endmodule

### design/queue_occupancy_statistics_core.sv
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   req_type, event_time
// output    out        out_valid / out_stall status, statistics snapshot
//
// One transaction in, one transaction out; a new event is taken every cycle unless the output stalls.
// An event passes through the input register, then updates the
// statistics registers, which double as the output register.
// rst_n clears all statistics and the time base to zero.
// A stalled output holds the snapshot and freezes the update; in_stall rises
// only while the input register is full and cannot move on.
module queue_occupancy_statistics_core #(
    parameter int TIME_BITS   = 32,
    parameter int CLIENT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [31:0] event_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] arrival_total,
    output logic [31:0] completion_total,
    output logic [15:0] clients_now,
    output logic [15:0] clients_peak,
    output logic [63:0] busy_ticks,
    output logic [63:0] observed_ticks,
    output logic [63:0] system_area,
    output logic [63:0] queue_area,
    output logic [31:0] latest_arrival_time
);
    import qos_pkg::*;

    logic                  in_valid_reg;
    req_t                  req_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic                  advance;

    logic                  out_valid_reg,   out_valid_next;
    status_t               status_reg,      status_next;
    logic [TIME_BITS-1:0]  prev_time_reg,   prev_time_next;
    logic [CLIENT_BITS-1:0] count_reg,      count_next;
    logic [CLIENT_BITS-1:0] peak_reg,       peak_next;
    logic [31:0]           arrivals_reg,    arrivals_next;
    logic [31:0]           completions_reg, completions_next;
    logic [ACC_BITS-1:0]   busy_reg,        busy_next;
    logic [ACC_BITS-1:0]   observe_reg,     observe_next;
    logic [ACC_BITS-1:0]   system_reg,      system_next;
    logic [ACC_BITS-1:0]   queue_reg,       queue_next;
    logic [31:0]           stamp_reg,       stamp_next;

    logic [TIME_BITS-1:0]  span;
    logic [CLIENT_BITS-1:0] queue_weight;
    logic                  occupied;
    logic [ACC_BITS-1:0]   system_sum;
    logic [ACC_BITS-1:0]   queue_sum;
    logic [CLIENT_BITS-1:0] count_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            req_reg  <= req_t'(req_type);
            time_reg <= TIME_BITS'(event_time);
        end
    end

    assign occupied     = (count_reg != '0);
    assign span         = time_reg - prev_time_reg;
    assign queue_weight = occupied ? count_reg - CLIENT_BITS'(1) : '0;
    assign count_inc    = (count_reg == {CLIENT_BITS{1'b1}}) ? count_reg
                                                             : count_reg + CLIENT_BITS'(1);

    qos_area_acc #(
        .TIME_BITS   (TIME_BITS),
        .CLIENT_BITS (CLIENT_BITS)
    ) u_system_area (
        .acc_in  (system_reg),
        .weight  (count_reg),
        .span    (span),
        .acc_out (system_sum)
    );

    qos_area_acc #(
        .TIME_BITS   (TIME_BITS),
        .CLIENT_BITS (CLIENT_BITS)
    ) u_queue_area (
        .acc_in  (queue_reg),
        .weight  (queue_weight),
        .span    (span),
        .acc_out (queue_sum)
    );

    always_comb
    begin
        out_valid_next   = advance ? 1'b1 : (out_valid_reg && out_stall);
        status_next      = status_reg;
        prev_time_next   = prev_time_reg;
        count_next       = count_reg;
        peak_next        = peak_reg;
        arrivals_next    = arrivals_reg;
        completions_next = completions_reg;
        busy_next        = busy_reg;
        observe_next     = observe_reg;
        system_next      = system_reg;
        queue_next       = queue_reg;
        stamp_next       = stamp_reg;

        if (advance)
        begin
            if (time_reg < prev_time_reg)
            begin
                status_next = STATUS_BACKWARDS;
            end
            else
            begin
                status_next    = STATUS_OK;
                prev_time_next = time_reg;
                observe_next   = sat_add(observe_reg, ACC_BITS'(span));
                if (occupied)
                begin
                    busy_next   = sat_add(busy_reg, ACC_BITS'(span));
                    system_next = system_sum;
                    queue_next  = queue_sum;
                end

                unique case (req_reg)
                    REQ_ARRIVAL:
                    begin
                        if (arrivals_reg != 32'hFFFF_FFFF)
                        begin
                            arrivals_next = arrivals_reg + 32'd1;
                        end
                        count_next = count_inc;
                        stamp_next = 32'(time_reg);
                        if (count_inc > peak_reg)
                        begin
                            peak_next = count_inc;
                        end
                    end
                    REQ_DEPARTURE:
                    begin
                        if (!occupied)
                        begin
                            status_next = STATUS_EMPTY_DEPART;
                        end
                        else
                        begin
                            count_next = count_reg - CLIENT_BITS'(1);
                            if (completions_reg != 32'hFFFF_FFFF)
                            begin
                                completions_next = completions_reg + 32'd1;
                            end
                        end
                    end
                    REQ_CLEAR:
                    begin
                        arrivals_next    = '0;
                        completions_next = '0;
                        peak_next        = '0;
                        busy_next        = '0;
                        observe_next     = '0;
                        system_next      = '0;
                        queue_next       = '0;
                        stamp_next       = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            prev_time_reg   <= '0;
            count_reg       <= '0;
            peak_reg        <= '0;
            arrivals_reg    <= '0;
            completions_reg <= '0;
            busy_reg        <= '0;
            observe_reg     <= '0;
            system_reg      <= '0;
            queue_reg       <= '0;
            stamp_reg       <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            prev_time_reg   <= prev_time_next;
            count_reg       <= count_next;
            peak_reg        <= peak_next;
            arrivals_reg    <= arrivals_next;
            completions_reg <= completions_next;
            busy_reg        <= busy_next;
            observe_reg     <= observe_next;
            system_reg      <= system_next;
            queue_reg       <= queue_next;
            stamp_reg       <= stamp_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign arrival_total       = arrivals_reg;
    assign completion_total    = completions_reg;
    assign clients_now         = 16'(count_reg);
    assign clients_peak        = 16'(peak_reg);
    assign busy_ticks          = busy_reg;
    assign observed_ticks      = observe_reg;
    assign system_area         = system_reg;
    assign queue_area          = queue_reg;
    assign latest_arrival_time = stamp_reg;

endmodule
